### sv/tick_timer_table_core_macros.svh
// Assertion macros for the tick timer table core.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TICK_TIMER_TABLE_CORE_MACROS_SVH
`define TICK_TIMER_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a condition holds at every clock edge out of reset.
`define TTT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Check that a trigger implies a consequence in the same cycle.
`define TTT_ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);
// Check that a trigger implies a consequence in the next cycle.
`define TTT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);
`else
`define TTT_ASSERT_ALWAYS(label, cond, msg)
`define TTT_ASSERT_IMPLIES(label, trig, cons, msg)
`define TTT_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

### sv/ttt_pkg.sv
// Types, sizes and field conversions for the tick timer table core.
// No dependencies; imported by the core.
`default_nettype none

package ttt_pkg;

  // Table sizing
  localparam int SLOTS      = 16;
  localparam int DELAY_BITS = 16;
  localparam int TAG_BITS   = 8;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] delay_seconds;
    logic [7:0]  timer_tag;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] expired_tag;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [DELAY_BITS-1:0] delay;
    logic [TAG_BITS-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Fit the 16-bit input delay to the stored width
  function automatic logic [DELAY_BITS-1:0] fit_delay(logic [15:0] d);
    logic [DELAY_BITS+15:0] w;
    w = {{DELAY_BITS{1'b0}}, d};
    return w[DELAY_BITS-1:0];
  endfunction

  // Fit the 8-bit input tag to the stored width
  function automatic logic [TAG_BITS-1:0] fit_tag(logic [7:0] t);
    logic [TAG_BITS+7:0] w;
    w = {{TAG_BITS{1'b0}}, t};
    return w[TAG_BITS-1:0];
  endfunction

  // Fit a stored tag to the 8-bit result field
  function automatic logic [7:0] out_tag(logic [TAG_BITS-1:0] t);
    logic [TAG_BITS+7:0] w;
    w = {8'd0, t};
    return w[7:0];
  endfunction

endpackage

`default_nettype wire

### sv/ttt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]              wdata_i,
  input  wire logic                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/tick_timer_table_core.sv
// An add, or a tick on an empty table, gives its result in the cycle after acceptance.
// A tick on a table of n entries stays busy while it walks the entries and then flushes;
// its final result follows in the cycle after the flush, expiries before it in table order.
// Adds are taken one per cycle while not busy; a tick walks one entry per cycle through the
// single RAM read port. Reset empties the table at once (entry count zero, no clearing pass);
// the receiver cannot stall, each result strobes for exactly one cycle.
`default_nettype none
`include "tick_timer_table_core_macros.svh"

module tick_timer_table_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire ttt_pkg::in_t  in_i,
  output logic               busy,
  output logic               strobe_o,
  output ttt_pkg::out_t      res_o
);

  import ttt_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    rd_q, rd_d;
  logic [CNT_W-1:0]    wr_q, wr_d;
  logic                pend_q, pend_d;
  logic [TAG_BITS-1:0] pend_tag_q, pend_tag_d;
  logic                strobe_q, strobe_d;
  out_t                res_q, res_d;

  logic               accept;
  logic               full;
  logic               more;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(SLOTS));
  assign more   = (rd_q < count_q);

  // Entry storage
  ttt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_i.cmd == CMD_TICK && count_q != '0) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!more) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath: read, count down, compact and report
  always_comb begin
    count_d    = count_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    pend_d     = pend_q;
    pend_tag_d = pend_tag_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_q[IDX_W-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = rd_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.cmd)
            CMD_ADD: begin
              strobe_d = 1'b1;
              if (full) begin
                res_d = '{status: ST_FULL, expired_tag: 8'd0, last: 1'b1};
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = count_q[IDX_W-1:0];
                ram_wdata.delay = fit_delay(in_i.delay_seconds);
                ram_wdata.tag   = fit_tag(in_i.timer_tag);
                count_d         = count_q + CNT_W'(1);
                res_d = '{status: ST_ADDED, expired_tag: 8'd0, last: 1'b1};
              end
            end
            CMD_TICK: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                res_d = '{status: ST_NONE, expired_tag: 8'd0, last: 1'b1};
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_d      = CNT_W'(1);
                wr_d      = '0;
                pend_d    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // Hold back each expiry until the next one or the flush so the final one can carry last
        if (ram_rdata.delay == '0) begin
          if (pend_q) begin
            strobe_d = 1'b1;
            res_d = '{status: ST_EXPIRED, expired_tag: out_tag(pend_tag_q), last: 1'b0};
          end
          pend_d     = 1'b1;
          pend_tag_d = ram_rdata.tag;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = wr_q[IDX_W-1:0];
          ram_wdata.delay = ram_rdata.delay - DELAY_BITS'(1);
          ram_wdata.tag   = ram_rdata.tag;
          wr_d            = wr_q + CNT_W'(1);
        end
        // Advance the read pointer
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = rd_q[IDX_W-1:0];
          rd_d      = rd_q + CNT_W'(1);
        end
      end
      S_FLUSH: begin
        strobe_d = 1'b1;
        count_d  = wr_q;
        if (pend_q) begin
          res_d = '{status: ST_EXPIRED, expired_tag: out_tag(pend_tag_q), last: 1'b1};
        end else begin
          res_d = '{status: ST_NONE, expired_tag: 8'd0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_tag_q <= pend_tag_d;
    res_q      <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  // Assertions
  `TTT_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(SLOTS), "entry count beyond table size")
  `TTT_ASSERT_IMPLIES(a_compact_behind, state_q == S_WALK, wr_q < rd_q, "write passed read")
  `TTT_ASSERT_IMPLIES(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "RAM clash")
  `TTT_ASSERT_NEXT(a_add_result, accept && in_i.cmd == CMD_ADD, strobe_o && res_o.last, "add lost")
  `TTT_ASSERT_NEXT(a_flush_result, state_q == S_FLUSH, strobe_o && res_o.last, "tick end lost")

endmodule

`default_nettype wire
